### design/otgv_pkg.sv
// Package for the three-wheel omni goal-velocity block.
// Types, constants and the CORDIC arctangent table shared by all modules.
// No dependencies.
`timescale 1ns / 1ps

package otgv_pkg;

    localparam int CORDIC_ITER_DEF = 16;
    localparam int SQRT_STAGES     = 32;
    localparam int DIV_STAGES      = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;
    localparam logic signed [17:0] MIX_TWO_THIRDS = 18'sd43713;
    localparam logic signed [17:0] MIX_ONE_THIRD  = 18'sd21823;
    localparam logic signed [17:0] MIX_ROOT_THIRD = 18'sd37814;
    localparam logic signed [25:0] WHEEL_LIMIT    = 26'sd65535;

    localparam logic [15:0] POS_DB_RESET    = 16'd256;
    localparam logic [15:0] HEAD_DB_RESET   = 16'd256;
    localparam logic [14:0] LIN_SPEED_RESET = 15'd4096;
    localparam logic [14:0] ANG_SPEED_RESET = 15'd6144;

    typedef enum logic [7:0] {
        CFG_POS_DB    = 8'd0,
        CFG_HEAD_DB   = 8'd1,
        CFG_LIN_SPEED = 8'd2,
        CFG_ANG_SPEED = 8'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        QUAD_AXIS = 3'd0,
        QUAD_I    = 3'd1,
        QUAD_II   = 3'd2,
        QUAD_III  = 3'd3,
        QUAD_IV   = 3'd4
    } quad_t;

    typedef struct packed {
        logic [15:0] pos_db;
        logic [15:0] head_db;
        logic [14:0] lin_speed;
        logic [14:0] ang_speed;
    } cfg_t;

    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [48:0]        sumsq;
        logic [14:0]        v;
        logic signed [15:0] w;
        logic signed [17:0] dw;
        quad_t              quad;
        logic signed [31:0] z;
        logic               flip;
    } item_t;

    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic signed [17:0] dw;
        quad_t              quad;
        logic [14:0]        v;
        logic signed [15:0] w;
        logic               flip;
        logic               nz;
        logic signed [31:0] z;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic [63:0]        n;
        logic [35:0]        rem;
        logic [31:0]        root;
        logic [47:0]        numx;
        logic [47:0]        numy;
        logic [15:0]        qx;
        logic [15:0]        qy;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [50:0] pcx;
        logic signed [50:0] psy;
        logic signed [50:0] pcy;
        logic signed [50:0] psx;
        logic signed [20:0] lx;
        logic signed [20:0] ly;
        logic signed [39:0] mpa;
        logic signed [39:0] mpb;
        logic signed [39:0] mpc;
        logic signed [39:0] mpd;
    } bk_t;

    typedef struct packed {
        logic signed [16:0] wheel_one_speed;
        logic signed [16:0] wheel_two_speed;
        logic signed [16:0] wheel_three_speed;
        logic [24:0]        target_distance;
        logic signed [17:0] heading_error;
        quad_t              quadrant_code;
    } result_t;

    // arctangent of 2^-i in degrees, Q.22
    function automatic logic signed [31:0] atan_q22(input int i);
        logic signed [31:0] a;
        case (i)
            0:       a = 32'sd188743680;
            1:       a = 32'sd111421900;
            2:       a = 32'sd58872272;
            3:       a = 32'sd29884485;
            4:       a = 32'sd15000234;
            5:       a = 32'sd7507429;
            6:       a = 32'sd3754631;
            7:       a = 32'sd1877430;
            8:       a = 32'sd938729;
            9:       a = 32'sd469366;
            10:      a = 32'sd234683;
            11:      a = 32'sd117342;
            12:      a = 32'sd58671;
            13:      a = 32'sd29335;
            14:      a = 32'sd14668;
            15:      a = 32'sd7334;
            16:      a = 32'sd3667;
            17:      a = 32'sd1833;
            18:      a = 32'sd917;
            19:      a = 32'sd458;
            20:      a = 32'sd229;
            21:      a = 32'sd115;
            22:      a = 32'sd57;
            23:      a = 32'sd29;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage

### design/otgv_front.sv
// Front pipeline: pose deltas, squared distance, deadband tests, heading reduction.
// Depends on otgv_pkg.
`timescale 1ns / 1ps

module otgv_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [23:0]   current_x,
    input  logic signed [23:0]   current_y,
    input  logic signed [16:0]   current_heading,
    input  logic signed [23:0]   target_x,
    input  logic signed [23:0]   target_y,
    input  logic signed [16:0]   target_heading,
    input  otgv_pkg::cfg_t       cfg,
    input  logic                 q_full,
    output logic                 q_push,
    output otgv_pkg::item_t      q_item
);
    import otgv_pkg::*;

    logic               adv;
    logic               v1_reg, v2_reg, v3_reg;
    logic signed [24:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [17:0] dw1_reg, dw2_reg, dw3_reg;
    logic signed [17:0] h1_reg, h2_reg;
    logic               flip2_reg, flip3_reg;
    quad_t              quad1_reg, quad2_reg, quad3_reg;
    logic [47:0]        sqx2_reg, sqy2_reg;
    logic [31:0]        pd2_reg;
    logic signed [15:0] w2_reg, w3_reg;
    logic [48:0]        sumsq3_reg;
    logic [14:0]        v3s_reg;
    logic signed [31:0] z3_reg;

    logic signed [24:0] dx_next, dy_next;
    logic signed [17:0] h0, h1_next, hh, h2_next;
    logic               flip_next;
    quad_t              quad_next;
    logic [24:0]        adx, ady;
    logic [17:0]        adw;
    logic signed [15:0] w_next;
    logic [48:0]        sumsq_next;

    assign adv      = !(v3_reg && q_full);
    assign in_ready = adv;
    assign q_push   = v3_reg && !q_full;

    always_comb
    begin
        dx_next = 25'(target_x) - 25'(current_x);
        dy_next = 25'(target_y) - 25'(current_y);
        h0      = 18'(current_heading);
        if (h0 < -18'sd46080)
        begin
            h1_next = h0 + 18'sd92160;
        end
        else if (h0 < 18'sd0)
        begin
            h1_next = h0 + 18'sd46080;
        end
        else if (h0 >= 18'sd46080)
        begin
            h1_next = h0 - 18'sd46080;
        end
        else
        begin
            h1_next = h0;
        end
        if (dx_next > 0 && dy_next > 0)
        begin
            quad_next = QUAD_I;
        end
        else if (dx_next < 0 && dy_next > 0)
        begin
            quad_next = QUAD_II;
        end
        else if (dx_next < 0 && dy_next < 0)
        begin
            quad_next = QUAD_III;
        end
        else if (dx_next > 0 && dy_next < 0)
        begin
            quad_next = QUAD_IV;
        end
        else
        begin
            quad_next = QUAD_AXIS;
        end
    end

    always_comb
    begin
        adx = dx1_reg[24] ? 25'(-dx1_reg) : 25'(dx1_reg);
        ady = dy1_reg[24] ? 25'(-dy1_reg) : 25'(dy1_reg);
        adw = dw1_reg[17] ? 18'(-dw1_reg) : 18'(dw1_reg);
        if (adw > {2'b00, cfg.head_db})
        begin
            w_next = dw1_reg[17] ? -$signed({1'b0, cfg.ang_speed})
                                 : $signed({1'b0, cfg.ang_speed});
        end
        else
        begin
            w_next = 16'sd0;
        end
        hh = (h1_reg >= 18'sd23040) ? h1_reg - 18'sd46080 : h1_reg;
        flip_next = 1'b0;
        if (hh > 18'sd11520)
        begin
            h2_next   = hh - 18'sd23040;
            flip_next = 1'b1;
        end
        else if (hh < -18'sd11520)
        begin
            h2_next   = hh + 18'sd23040;
            flip_next = 1'b1;
        end
        else
        begin
            h2_next = hh;
        end
    end

    assign sumsq_next = 49'(sqx2_reg) + 49'(sqy2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg   <= dx_next;
            dy1_reg   <= dy_next;
            dw1_reg   <= 18'(target_heading) - 18'(current_heading);
            h1_reg    <= h1_next;
            quad1_reg <= quad_next;

            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            dw2_reg   <= dw1_reg;
            quad2_reg <= quad1_reg;
            sqx2_reg  <= 48'(adx[23:0]) * 48'(adx[23:0]);
            sqy2_reg  <= 48'(ady[23:0]) * 48'(ady[23:0]);
            pd2_reg   <= 32'(cfg.pos_db) * 32'(cfg.pos_db);
            w2_reg    <= w_next;
            h2_reg    <= h2_next;
            flip2_reg <= flip_next;

            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            dw3_reg    <= dw2_reg;
            quad3_reg  <= quad2_reg;
            sumsq3_reg <= sumsq_next;
            v3s_reg    <= (sumsq_next > 49'(pd2_reg)) ? cfg.lin_speed : 15'd0;
            w3_reg     <= w2_reg;
            z3_reg     <= $signed(32'(h2_reg)) <<< 15;
            flip3_reg  <= flip2_reg;
        end
    end

    always_comb
    begin
        q_item.dx    = dx3_reg;
        q_item.dy    = dy3_reg;
        q_item.sumsq = sumsq3_reg;
        q_item.v     = v3s_reg;
        q_item.w     = w3_reg;
        q_item.dw    = dw3_reg;
        q_item.quad  = quad3_reg;
        q_item.z     = z3_reg;
        q_item.flip  = flip3_reg;
    end

endmodule

### design/otgv_queue.sv
// Short queue between the front and back pipelines.
// Depends on otgv_pkg.
`timescale 1ns / 1ps

module otgv_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  otgv_pkg::item_t push_item,
    input  logic            pop,
    output otgv_pkg::item_t head_item,
    output logic            full,
    output logic            empty
);
    import otgv_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t             mem [QUEUE_DEPTH];
    logic [PW-1:0]     wptr_reg, rptr_reg;
    logic [PW:0]       count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_item;
        end
    end

endmodule

### design/otgv_back.sv
// Back pipeline: square root, direction divide, CORDIC rotation, wheel mixing.
// Depends on otgv_pkg.
`timescale 1ns / 1ps

module otgv_back
#(
    parameter int CORDIC_ITERATIONS = otgv_pkg::CORDIC_ITER_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  otgv_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output otgv_pkg::result_t out_data
);
    import otgv_pkg::*;

    localparam int NUM_STAGE = SQRT_STAGES;
    localparam int DIV_BASE  = NUM_STAGE + 1;
    localparam int DIR_STAGE = DIV_BASE + DIV_STAGES;
    localparam int PROD      = DIR_STAGE + 1;
    localparam int LSUM      = PROD + 1;
    localparam int MIXP      = LSUM + 1;
    localparam int LAST      = MIXP + 1;

    bk_t     st_reg  [0:LAST];
    bk_t     st_next [0:LAST];
    logic    vld_reg [0:LAST];
    logic    adv;
    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;

    assign adv       = !out_valid_reg || out_ready;
    assign q_pop     = adv && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        st_next[0]       = '0;
        st_next[0].dx    = q_item.dx;
        st_next[0].dy    = q_item.dy;
        st_next[0].dw    = q_item.dw;
        st_next[0].quad  = q_item.quad;
        st_next[0].v     = q_item.v;
        st_next[0].w     = q_item.w;
        st_next[0].flip  = q_item.flip;
        st_next[0].nz    = |q_item.sumsq;
        st_next[0].z     = q_item.z;
        st_next[0].cx    = CORDIC_GAIN;
        st_next[0].cy    = 34'sd0;
        st_next[0].n     = {1'b0, q_item.sumsq, 14'd0};
    end

    // one root bit per stage; CORDIC iterations share the first stages
    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        logic [35:0]        rem_sh, trial;
        logic signed [33:0] xs, ys;
        always_comb
        begin
            st_next[k+1]   = st_reg[k];
            rem_sh         = {st_reg[k].rem[33:0], st_reg[k].n[63:62]};
            trial          = {2'b00, st_reg[k].root, 2'b01};
            xs             = $signed(st_reg[k].cx) >>> k;
            ys             = $signed(st_reg[k].cy) >>> k;
            st_next[k+1].n = {st_reg[k].n[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                st_next[k+1].rem  = rem_sh - trial;
                st_next[k+1].root = {st_reg[k].root[30:0], 1'b1};
            end
            else
            begin
                st_next[k+1].rem  = rem_sh;
                st_next[k+1].root = {st_reg[k].root[30:0], 1'b0};
            end
            if (k < CORDIC_ITERATIONS)
            begin
                if (!st_reg[k].z[31])
                begin
                    st_next[k+1].cx = st_reg[k].cx - ys;
                    st_next[k+1].cy = st_reg[k].cy + xs;
                    st_next[k+1].z  = st_reg[k].z - atan_q22(k);
                end
                else
                begin
                    st_next[k+1].cx = st_reg[k].cx + ys;
                    st_next[k+1].cy = st_reg[k].cy - xs;
                    st_next[k+1].z  = st_reg[k].z + atan_q22(k);
                end
            end
        end
    end

    logic [24:0] nadx, nady;
    always_comb
    begin
        st_next[DIV_BASE]      = st_reg[NUM_STAGE];
        nadx = st_reg[NUM_STAGE].dx[24] ? 25'(-st_reg[NUM_STAGE].dx)
                                        : 25'(st_reg[NUM_STAGE].dx);
        nady = st_reg[NUM_STAGE].dy[24] ? 25'(-st_reg[NUM_STAGE].dy)
                                        : 25'(st_reg[NUM_STAGE].dy);
        st_next[DIV_BASE].numx = ((48'(st_reg[NUM_STAGE].v) * 48'(nadx[23:0])) << 7)
                               + 48'(st_reg[NUM_STAGE].root >> 1);
        st_next[DIV_BASE].numy = ((48'(st_reg[NUM_STAGE].v) * 48'(nady[23:0])) << 7)
                               + 48'(st_reg[NUM_STAGE].root >> 1);
        st_next[DIV_BASE].qx   = '0;
        st_next[DIV_BASE].qy   = '0;
    end

    // restoring divide by the radius, quotient bit 15 first
    for (genvar d = 0; d < DIV_STAGES; d++)
    begin : g_div
        localparam int B = DIV_STAGES - 1 - d;
        logic [47:0] dvs;
        always_comb
        begin
            st_next[DIV_BASE+d+1] = st_reg[DIV_BASE+d];
            dvs = 48'(st_reg[DIV_BASE+d].root) << B;
            if (st_reg[DIV_BASE+d].numx >= dvs)
            begin
                st_next[DIV_BASE+d+1].numx  = st_reg[DIV_BASE+d].numx - dvs;
                st_next[DIV_BASE+d+1].qx[B] = 1'b1;
            end
            if (st_reg[DIV_BASE+d].numy >= dvs)
            begin
                st_next[DIV_BASE+d+1].numy  = st_reg[DIV_BASE+d].numy - dvs;
                st_next[DIV_BASE+d+1].qy[B] = 1'b1;
            end
        end
    end

    logic [15:0] mx, my;
    always_comb
    begin
        st_next[PROD] = st_reg[DIR_STAGE];
        mx = (st_reg[DIR_STAGE].qx > 16'(st_reg[DIR_STAGE].v)) ? 16'(st_reg[DIR_STAGE].v)
                                                               : st_reg[DIR_STAGE].qx;
        my = (st_reg[DIR_STAGE].qy > 16'(st_reg[DIR_STAGE].v)) ? 16'(st_reg[DIR_STAGE].v)
                                                               : st_reg[DIR_STAGE].qy;
        if (st_reg[DIR_STAGE].nz)
        begin
            st_next[PROD].vx = st_reg[DIR_STAGE].dx[24] ? -$signed(mx) : $signed(mx);
            st_next[PROD].vy = st_reg[DIR_STAGE].dy[24] ? -$signed(my) : $signed(my);
        end
        else
        begin
            st_next[PROD].vx = 16'sd0;
            st_next[PROD].vy = 16'sd0;
        end
        if (st_reg[DIR_STAGE].flip)
        begin
            st_next[PROD].cx = -st_reg[DIR_STAGE].cx;
            st_next[PROD].cy = -st_reg[DIR_STAGE].cy;
        end
    end

    always_comb
    begin
        st_next[LSUM]     = st_reg[PROD];
        st_next[LSUM].pcx = 51'(st_reg[PROD].cx) * 51'(st_reg[PROD].vx);
        st_next[LSUM].psy = 51'(st_reg[PROD].cy) * 51'(st_reg[PROD].vy);
        st_next[LSUM].pcy = 51'(st_reg[PROD].cx) * 51'(st_reg[PROD].vy);
        st_next[LSUM].psx = 51'(st_reg[PROD].cy) * 51'(st_reg[PROD].vx);
    end

    logic signed [50:0] sx, sy;
    always_comb
    begin
        st_next[MIXP]    = st_reg[LSUM];
        sx = st_reg[LSUM].pcx + st_reg[LSUM].psy + 51'sd536870912;
        sy = st_reg[LSUM].pcy - st_reg[LSUM].psx + 51'sd536870912;
        st_next[MIXP].lx = 21'(sx >>> 30);
        st_next[MIXP].ly = 21'(sy >>> 30);
    end

    always_comb
    begin
        st_next[LAST]     = st_reg[MIXP];
        st_next[LAST].mpa = 40'(st_reg[MIXP].lx) * 40'(MIX_TWO_THIRDS);
        st_next[LAST].mpb = 40'(st_reg[MIXP].lx) * 40'(MIX_ONE_THIRD);
        st_next[LAST].mpc = 40'(st_reg[MIXP].ly) * 40'(MIX_ROOT_THIRD);
        st_next[LAST].mpd = 40'(st_reg[MIXP].w) * 40'(MIX_ONE_THIRD);
    end

    function automatic logic signed [16:0] sat17(input logic signed [41:0] s);
        logic signed [25:0] t;
        logic signed [16:0] r;
        t = 26'(s >>> 16);
        if (t > WHEEL_LIMIT)
        begin
            r = 17'(WHEEL_LIMIT);
        end
        else if (t < -WHEEL_LIMIT)
        begin
            r = 17'(-WHEEL_LIMIT);
        end
        else
        begin
            r = 17'(t);
        end
        return r;
    endfunction

    logic signed [41:0] s1, s2, s3;
    always_comb
    begin
        s1 = 42'(st_reg[LAST].mpa) + 42'(st_reg[LAST].mpd) + 42'sd32768;
        s2 = 42'(st_reg[LAST].mpc) - 42'(st_reg[LAST].mpb) + 42'(st_reg[LAST].mpd)
           + 42'sd32768;
        s3 = 42'(st_reg[LAST].mpd) - 42'(st_reg[LAST].mpb) - 42'(st_reg[LAST].mpc)
           + 42'sd32768;
        out_next.wheel_one_speed   = sat17(s1);
        out_next.wheel_two_speed   = sat17(s2);
        out_next.wheel_three_speed = sat17(s3);
        out_next.target_distance   = st_reg[LAST].root[31:7];
        out_next.heading_error     = st_reg[LAST].dw;
        out_next.quadrant_code     = st_reg[LAST].quad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= !q_empty;
            for (int i = 1; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            out_reg <= out_next;
        end
    end

endmodule

### design/omni_three_wheel_goal_velocity.sv
// Three-wheel omni goal velocity: one result per pose pair, one transfer per cycle when
// not stalled by output back-pressure. Path from input transfer to output valid: 3 front
// stages (the first loaded by the transfer itself), the queue, 54 back stages
// (entry, 32 root, 1 numerator, 16 divide, 4 rotate and mix) and the output
// register. Throughput is one item per cycle while the output is not stalled.
// Reset clears pipeline valids, queue pointers and restores register defaults.
`timescale 1ns / 1ps

module omni_three_wheel_goal_velocity
#(
    parameter int CORDIC_ITERATIONS = otgv_pkg::CORDIC_ITER_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // current_x, current_y, current_heading, target_x, target_y, target_heading
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // wheel_one_speed, wheel_two_speed, wheel_three_speed, target_distance,
    // heading_error, quadrant_code
    output logic [103:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import otgv_pkg::*;

    cfg_t    cfg_reg;
    logic    q_push, q_pop, q_full, q_empty;
    item_t   push_item, head_item;
    result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_db    <= POS_DB_RESET;
            cfg_reg.head_db   <= HEAD_DB_RESET;
            cfg_reg.lin_speed <= LIN_SPEED_RESET;
            cfg_reg.ang_speed <= ANG_SPEED_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POS_DB:    cfg_reg.pos_db    <= cfg_data;
                CFG_HEAD_DB:   cfg_reg.head_db   <= cfg_data;
                CFG_LIN_SPEED: cfg_reg.lin_speed <= cfg_data[14:0];
                CFG_ANG_SPEED: cfg_reg.ang_speed <= cfg_data[14:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    otgv_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .current_x       (s_axis_tdata[23:0]),
        .current_y       (s_axis_tdata[47:24]),
        .current_heading (s_axis_tdata[64:48]),
        .target_x        (s_axis_tdata[88:65]),
        .target_y        (s_axis_tdata[112:89]),
        .target_heading  (s_axis_tdata[129:113]),
        .cfg             (cfg_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (push_item)
    );

    otgv_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    otgv_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {7'd0, res.quadrant_code, res.heading_error, res.target_distance,
                           res.wheel_three_speed, res.wheel_two_speed, res.wheel_one_speed};

    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_empty))
        else $error("queue underflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.quadrant_code == QUAD_AXIS || res.quadrant_code == QUAD_I
            || res.quadrant_code == QUAD_II || res.quadrant_code == QUAD_III
            || res.quadrant_code == QUAD_IV))
        else $error("bad quadrant code");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.wheel_one_speed != -17'sd65536
            && res.wheel_two_speed != -17'sd65536 && res.wheel_three_speed != -17'sd65536))
        else $error("wheel speed beyond saturation limit");

endmodule
